// File: rtl/ppu_pkg.sv
`default_nettype none

package ppu_pkg;

   localparam int POS_W      = 32;
   localparam int RAMP_W     = 16;
   localparam int TIME_W     = 40;
   localparam int PAL_W      = 8;
   localparam int KIND_W     = 3;
   localparam int FT_W       = 17;
   localparam int GRAV_W     = 16;
   localparam int DVEL_W     = FT_W + 2;
   localparam int GP_W       = FT_W + GRAV_W;
   localparam int GDIV_W     = 29;
   localparam int G30_W      = GP_W + 1;
   localparam int SAT_W      = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int SETTLE_W   = 2;
   localparam int PRODP_W    = POS_W + FT_W + 1;
   localparam int PRODV_W    = POS_W + DVEL_W + 1;
   localparam int INC_W      = 21;

   localparam logic [KIND_W-1:0] KIND_STATIC   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GRAV     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SLOWGRAV = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPLODE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EXPLODE2 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_BLOB     = 3'd6;
   localparam logic [KIND_W-1:0] KIND_BLOB2    = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TIME   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_TIME = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSED       = 2'd3;

   localparam logic [GRAV_W-1:0]   GRAVITY_RESET = 16'd800;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV5_SHIFT = 34;
   localparam logic [15:0] ROUND_HALF = 16'd32768;

   localparam logic [3:0]        RAMP_K_FIRE     = 4'd5;
   localparam logic [3:0]        RAMP_K_EXPLODE  = 4'd10;
   localparam logic [3:0]        RAMP_K_EXPLODE2 = 4'd15;
   localparam logic [RAMP_W-1:0] RAMP_END_FIRE   = 16'd24576;
   localparam logic [RAMP_W-1:0] RAMP_END_EXPL   = 16'd32768;
   localparam logic [RAMP_W-1:0] RAMP_MAX        = 16'hFFFF;
   localparam logic [INC_W-1:0]  RAMP_ROUND      = 21'd8;

   localparam logic signed [TIME_W-1:0] EXPIRED_TIME = 40'shFF_FFFF_0000;
   localparam logic signed [SAT_W-1:0]  SAT_HI       = 40'sh00_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0]  SAT_LO       = 40'shFF_8000_0000;

   localparam logic [7:0][PAL_W-1:0] FIRE_TAB =
      {8'h00, 8'h00, 8'h03, 8'h04, 8'h05, 8'h06, 8'h6b, 8'h6d};
   localparam logic [7:0][PAL_W-1:0] EXPL_TAB =
      {8'h61, 8'h63, 8'h65, 8'h67, 8'h69, 8'h6b, 8'h6d, 8'h6f};
   localparam logic [7:0][PAL_W-1:0] EXPL2_TAB =
      {8'h66, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f};

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [POS_W-1:0]  vel_x;
      logic signed [POS_W-1:0]  vel_y;
      logic signed [POS_W-1:0]  vel_z;
      logic [RAMP_W-1:0]        ramp_in;
      logic signed [TIME_W-1:0] expiry;
      logic [PAL_W-1:0]         palette_index;
   } req_type;

   typedef struct packed {
      logic                     alive;
      logic signed [POS_W-1:0]  new_pos_x;
      logic signed [POS_W-1:0]  new_pos_y;
      logic signed [POS_W-1:0]  new_pos_z;
      logic signed [POS_W-1:0]  new_vel_x;
      logic signed [POS_W-1:0]  new_vel_y;
      logic signed [POS_W-1:0]  new_vel_z;
      logic [RAMP_W-1:0]        ramp_out;
      logic signed [TIME_W-1:0] new_expiry;
      logic [PAL_W-1:0]         new_palette_index;
   } rsp_type;

   typedef struct packed {
      logic [FT_W-1:0]   ft;
      logic [DVEL_W-1:0] dvel;
      logic [GDIV_W-1:0] grav;
      logic [G30_W-1:0]  grav30;
   } cfg_type;

   typedef struct packed {
      logic scale_en;
      logic scale_up;
      logic use_ft;
   } lane_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [RAMP_W-1:0]        ramp;
      logic signed [TIME_W-1:0] expiry;
      logic [PAL_W-1:0]         pal;
      logic                     dead;
   } side_type;

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[POS_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ppu_cfg.sv
`default_nettype none

module ppu_cfg import ppu_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [TIME_W-1:0]           csr_wdata,
   output logic signed [TIME_W-1:0]    current_time,
   output cfg_type                     cfg,
   output logic                        settle_busy
);

   logic [FT_W-1:0]          frame_time_ff, frame_time_in;
   logic [GRAV_W-1:0]        gravity_ff, gravity_in;
   logic signed [TIME_W-1:0] current_time_ff, current_time_in;
   logic                     paused_ff, paused_in;
   logic [SETTLE_W-1:0]      settle_ff, settle_in;

   logic [FT_W-1:0]   ft_eff;
   logic [FT_W-1:0]   ft_ff;
   logic [DVEL_W-1:0] dvel_ff;
   logic [GP_W-1:0]   gp_ff;
   logic [G30_W-1:0]  grav30_ff;
   logic [63:0]       div_ff;
   logic [GP_W:0]     gp_p10;
   logic [GP_W+1:0]   gp3;

   always_comb begin
      frame_time_in   = frame_time_ff;
      gravity_in      = gravity_ff;
      current_time_in = current_time_ff;
      paused_in       = paused_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_TIME:   frame_time_in   = csr_wdata[FT_W-1:0];
            CSR_GRAVITY:      gravity_in      = csr_wdata[GRAV_W-1:0];
            CSR_CURRENT_TIME: current_time_in = csr_wdata;
            CSR_PAUSED:       paused_in       = csr_wdata[0];
            default: ;
         endcase
      end
      if (csr_valid) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff   <= '0;
         gravity_ff      <= GRAVITY_RESET;
         current_time_ff <= '0;
         paused_ff       <= 1'b0;
         settle_ff       <= SETTLE_CYCLES;
      end else begin
         frame_time_ff   <= frame_time_in;
         gravity_ff      <= gravity_in;
         current_time_ff <= current_time_in;
         paused_ff       <= paused_in;
         settle_ff       <= settle_in;
      end
   end

   // Derived frame constants; gravity / 20 is done as (gp + 10) / 4 times 1/5.
   assign ft_eff = paused_ff ? '0 : frame_time_ff;
   assign gp_p10 = (GP_W+1)'(gp_ff) + (GP_W+1)'(10);
   assign gp3    = (GP_W+2)'(gp_ff) + (GP_W+2)'({gp_ff, 1'b0}) + (GP_W+2)'(1);

   always_ff @(posedge clock) begin
      ft_ff     <= ft_eff;
      dvel_ff   <= {ft_eff, 2'b00};
      gp_ff     <= GP_W'(ft_eff) * GP_W'(gravity_ff);
      grav30_ff <= gp3[GP_W+1:1];
      div_ff    <= 64'(gp_p10[GP_W:2]) * 64'(DIV5_MAGIC);
   end

   assign cfg.ft        = ft_ff;
   assign cfg.dvel      = dvel_ff;
   assign cfg.grav      = div_ff[DIV5_SHIFT+GDIV_W-1:DIV5_SHIFT];
   assign cfg.grav30    = grav30_ff;
   assign current_time  = current_time_ff;
   assign settle_busy   = (settle_ff != '0);

endmodule

`default_nettype wire

// File: rtl/ppu_lane.sv
`default_nettype none

module ppu_lane import ppu_pkg::*; (
   input  logic                    clock,
   input  logic signed [POS_W-1:0] pos,
   input  logic signed [POS_W-1:0] vel,
   input  lane_mode_type           mode,
   input  cfg_type                 cfg,
   output logic signed [POS_W-1:0] new_pos,
   output logic signed [POS_W-1:0] new_vel
);

   logic signed [POS_W-1:0]   pos_ff, vel_ff;
   lane_mode_type             mode_ff;
   logic signed [PRODP_W-1:0] prodp_ff, prodp_in;
   logic signed [PRODV_W-1:0] prodv_ff, prodv_in;
   logic [DVEL_W-1:0]         factor;
   logic signed [POS_W-1:0]   new_pos_ff, new_pos_in;
   logic signed [POS_W-1:0]   new_vel_ff, new_vel_in;
   logic signed [PRODP_W-1:0] rp;
   logic signed [PRODV_W-1:0] rv;
   logic signed [SAT_W-1:0]   pos_sum, vel_up, vel_dn;

   always_comb begin
      factor   = mode.use_ft ? DVEL_W'(cfg.ft) : cfg.dvel;
      prodp_in = PRODP_W'(vel) * PRODP_W'($signed({1'b0, cfg.ft}));
      prodv_in = PRODV_W'(vel) * PRODV_W'($signed({1'b0, factor}));
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos;
      vel_ff   <= vel;
      mode_ff  <= mode;
      prodp_ff <= prodp_in;
      prodv_ff <= prodv_in;
   end

   always_comb begin
      rp      = prodp_ff + PRODP_W'(ROUND_HALF);
      rv      = prodv_ff + PRODV_W'(ROUND_HALF);
      pos_sum = SAT_W'(pos_ff) + SAT_W'($signed(rp[PRODP_W-1:16]));
      vel_up  = SAT_W'(vel_ff) + SAT_W'($signed(rv[PRODV_W-1:16]));
      vel_dn  = SAT_W'(vel_ff) - SAT_W'($signed(rv[PRODV_W-1:16]));
      new_pos_in = sat32(pos_sum);
      if (!mode_ff.scale_en) begin
         new_vel_in = vel_ff;
      end else if (mode_ff.scale_up) begin
         new_vel_in = sat32(vel_up);
      end else begin
         new_vel_in = sat32(vel_dn);
      end
   end

   always_ff @(posedge clock) begin
      new_pos_ff <= new_pos_in;
      new_vel_ff <= new_vel_in;
   end

   assign new_pos = new_pos_ff;
   assign new_vel = new_vel_ff;

endmodule

`default_nettype wire

// File: rtl/ppu_merge.sv
`default_nettype none

module ppu_merge import ppu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid,
   input  side_type                side,
   input  cfg_type                 cfg,
   input  logic signed [POS_W-1:0] pos_x,
   input  logic signed [POS_W-1:0] pos_y,
   input  logic signed [POS_W-1:0] pos_z,
   input  logic signed [POS_W-1:0] vel_x,
   input  logic signed [POS_W-1:0] vel_y,
   input  logic signed [POS_W-1:0] vel_z,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data
);

   logic                    strobe_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic signed [SAT_W-1:0] vz, vz_adj;
   logic [3:0]              ramp_k;
   logic [RAMP_W-1:0]       ramp_end;
   logic                    has_ramp;
   logic [INC_W-1:0]        inc_full;
   logic [RAMP_W+1:0]       ramp_sum;
   logic [RAMP_W-1:0]       ramp_new;
   logic                    ramp_done;
   logic [2:0]              ramp_idx;
   logic [PAL_W-1:0]        pal_tab;

   always_comb begin
      vz = SAT_W'(vel_z);
      case (side.kind)
         KIND_GRAV, KIND_SLOWGRAV, KIND_BLOB, KIND_BLOB2: vz_adj = vz - SAT_W'(cfg.grav);
         KIND_FIRE:                                       vz_adj = vz + SAT_W'(cfg.grav);
         KIND_EXPLODE, KIND_EXPLODE2:                     vz_adj = vz - SAT_W'(cfg.grav30);
         default:                                         vz_adj = vz;
      endcase

      case (side.kind)
         KIND_FIRE: begin
            has_ramp = 1'b1;
            ramp_k   = RAMP_K_FIRE;
            ramp_end = RAMP_END_FIRE;
         end
         KIND_EXPLODE: begin
            has_ramp = 1'b1;
            ramp_k   = RAMP_K_EXPLODE;
            ramp_end = RAMP_END_EXPL;
         end
         KIND_EXPLODE2: begin
            has_ramp = 1'b1;
            ramp_k   = RAMP_K_EXPLODE2;
            ramp_end = RAMP_END_EXPL;
         end
         default: begin
            has_ramp = 1'b0;
            ramp_k   = '0;
            ramp_end = RAMP_END_EXPL;
         end
      endcase

      inc_full  = INC_W'(cfg.ft) * INC_W'(ramp_k) + RAMP_ROUND;
      ramp_sum  = (RAMP_W+2)'(side.ramp) + (RAMP_W+2)'(inc_full[INC_W-1:4]);
      ramp_new  = (ramp_sum[RAMP_W+1:RAMP_W] != 2'b00) ? RAMP_MAX : ramp_sum[RAMP_W-1:0];
      ramp_done = (ramp_new >= ramp_end);
      ramp_idx  = ramp_new[14:12];

      case (side.kind)
         KIND_FIRE:    pal_tab = FIRE_TAB[ramp_idx];
         KIND_EXPLODE: pal_tab = EXPL_TAB[ramp_idx];
         default:      pal_tab = EXPL2_TAB[ramp_idx];
      endcase

      rsp_in = '0;
      if (!side.dead) begin
         rsp_in.alive             = 1'b1;
         rsp_in.new_pos_x         = pos_x;
         rsp_in.new_pos_y         = pos_y;
         rsp_in.new_pos_z         = pos_z;
         rsp_in.new_vel_x         = vel_x;
         rsp_in.new_vel_y         = vel_y;
         rsp_in.new_vel_z         = sat32(vz_adj);
         rsp_in.ramp_out          = side.ramp;
         rsp_in.new_expiry        = side.expiry;
         rsp_in.new_palette_index = side.pal;
         if (has_ramp) begin
            rsp_in.ramp_out = ramp_new;
            if (ramp_done) begin
               rsp_in.new_expiry = EXPIRED_TIME;
            end else begin
               rsp_in.new_palette_index = pal_tab;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/particle_physics_update_top.sv
// Each accepted beat passes the request register, the lane product and result registers and the merge register.
// Throughput: one particle per cycle while busy is low; three axis lanes and one merge stage are fully pipelined.
// Busy is high during reset and after it while the settle counter runs down, and again after
// every configuration write while the derived gravity terms settle.
// Reset is synchronous and active high; it resets the configuration registers and clears the strobe and the valid bits.
// Results are shown for one cycle each; the receiver cannot stall.
`default_nettype none

module particle_physics_update_top import ppu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   cfg_type                  cfg;
   logic signed [TIME_W-1:0] current_time;
   logic                     settle_busy;
   logic                     accept;

   logic     v1_ff, v2_ff, v3_ff;
   req_type  req1_ff;
   logic     dead1_ff;
   side_type side1, side2_ff, side3_ff;

   lane_mode_type mode_xy, mode_z;

   logic signed [POS_W-1:0] lx_pos, ly_pos, lz_pos, lx_vel, ly_vel, lz_vel;

   ppu_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .current_time (current_time),
      .cfg          (cfg),
      .settle_busy  (settle_busy)
   );

   assign csr_ready = 1'b1;
   assign busy      = reset | settle_busy;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      req1_ff  <= req_data;
      dead1_ff <= (req_data.expiry < current_time);
      side2_ff <= side1;
      side3_ff <= side2_ff;
   end

   always_comb begin
      side1.kind   = req1_ff.kind;
      side1.ramp   = req1_ff.ramp_in;
      side1.expiry = req1_ff.expiry;
      side1.pal    = req1_ff.palette_index;
      side1.dead   = dead1_ff;

      mode_xy.scale_en = req1_ff.kind inside {KIND_EXPLODE, KIND_EXPLODE2, KIND_BLOB, KIND_BLOB2};
      mode_xy.scale_up = req1_ff.kind inside {KIND_EXPLODE, KIND_BLOB};
      mode_xy.use_ft   = (req1_ff.kind == KIND_EXPLODE2);
      mode_z.scale_en  = req1_ff.kind inside {KIND_EXPLODE, KIND_EXPLODE2, KIND_BLOB};
      mode_z.scale_up  = mode_xy.scale_up;
      mode_z.use_ft    = mode_xy.use_ft;
   end

   ppu_lane u_lane_x (
      .clock   (clock),
      .pos     (req1_ff.pos_x),
      .vel     (req1_ff.vel_x),
      .mode    (mode_xy),
      .cfg     (cfg),
      .new_pos (lx_pos),
      .new_vel (lx_vel)
   );

   ppu_lane u_lane_y (
      .clock   (clock),
      .pos     (req1_ff.pos_y),
      .vel     (req1_ff.vel_y),
      .mode    (mode_xy),
      .cfg     (cfg),
      .new_pos (ly_pos),
      .new_vel (ly_vel)
   );

   ppu_lane u_lane_z (
      .clock   (clock),
      .pos     (req1_ff.pos_z),
      .vel     (req1_ff.vel_z),
      .mode    (mode_z),
      .cfg     (cfg),
      .new_pos (lz_pos),
      .new_vel (lz_vel)
   );

   ppu_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid      (v3_ff),
      .side       (side3_ff),
      .cfg        (cfg),
      .pos_x      (lx_pos),
      .pos_y      (ly_pos),
      .pos_z      (lz_pos),
      .vel_x      (lx_vel),
      .vel_y      (ly_vel),
      .vel_z      (lz_vel),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/ppu_checker.sv
`default_nettype none

module ppu_checker import ppu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data,
   input logic    csr_valid
);

   // Every accepted beat produces exactly one result, and every result comes from an accepted beat.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("accepted beat produced no result");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("result without an accepted beat");

   // A dead particle reports its fields cleared; pos x, vel z, ramp, expiry and palette index are checked.
   a_dead_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.alive) |->
         (rsp_data.new_pos_x == '0 && rsp_data.new_vel_z == '0 &&
          rsp_data.ramp_out == '0 && rsp_data.new_expiry == '0 &&
          rsp_data.new_palette_index == '0))
      else $error("dead particle result not cleared");

   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> busy)
      else $error("busy not raised after configuration write");

endmodule

bind particle_physics_update_top ppu_checker u_ppu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .csr_valid  (csr_valid)
);

`default_nettype wire

// File: verif/particle_physics_update_top_tb.sv
`timescale 1ns / 1ps

module particle_physics_update_top_tb;
   import ppu_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int LATENCY         = 4;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int MAX_PRINTED     = 40;

   localparam longint TIME_MAX = 64'sd549755813887;
   localparam longint TIME_MIN = -64'sd549755813888;
   localparam longint Q16_HI   = 64'sd2147483647;
   localparam longint Q16_LO   = -64'sd2147483648;

   localparam logic [31:0] POS_TOP = 32'h7fff_ffff;
   localparam logic [31:0] POS_BOT = 32'h8000_0000;
   localparam logic [39:0] T_NOW   = 40'd6553600;

   localparam logic [0:7][7:0] FIRE_COLORS =
      {8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00};
   localparam logic [0:7][7:0] BURST_COLORS =
      {8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
   localparam logic [0:7][7:0] BURST2_COLORS =
      {8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

   class frame_update_scoreboard;
      longint frame_time;
      longint gravity;
      longint cur_time;
      bit     paused;
      rsp_type expected_particles[$];
      int mismatches;
      int results_seen;
      int expired_seen;
      int ramps_finished;

      function new();
         frame_time = 0;
         gravity    = 800;
         cur_time   = 0;
         paused     = 1'b0;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] v);
         case (idx)
            CSR_FRAME_TIME:   frame_time = longint'(v[16:0]);
            CSR_GRAVITY:      gravity    = longint'(v[15:0]);
            CSR_CURRENT_TIME: cur_time   = longint'($signed(v));
            CSR_PAUSED:       paused     = v[0];
            default: ;
         endcase
      endfunction

      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clamp_q16(longint v);
         if (v > Q16_HI) return Q16_HI;
         if (v < Q16_LO) return Q16_LO;
         return v;
      endfunction

      function longint scaled(longint v, longint f, bit up);
         longint d;
         d = round_shift(v * f, 16);
         return clamp_q16(up ? v + d : v - d);
      endfunction

      function void ramp_advance(longint ft, longint k, longint lim,
                                 logic [0:7][7:0] colors, inout longint ramp,
                                 inout longint expiry, inout logic [7:0] pal);
         ramp = ramp + ((ft * k + 8) >>> 4);
         if (ramp > 65535) ramp = 65535;
         if (ramp >= (lim <<< 12)) begin
            expiry = -65536;
            ramps_finished++;
         end else begin
            pal = colors[int'((ramp >>> 12) & 7)];
         end
      endfunction

      function rsp_type advance_particle(req_type p);
         rsp_type r;
         longint ft, gp, grav, grav30, dvel, ramp, expiry;
         longint pos[3];
         longint vel[3];
         logic [7:0] pal;
         r = '0;
         ft = paused ? 0 : frame_time;
         expiry = longint'($signed(p.expiry));
         if (expiry < cur_time) return r;
         ramp = longint'(p.ramp_in);
         pal = p.palette_index;
         pos[0] = longint'($signed(p.pos_x));
         pos[1] = longint'($signed(p.pos_y));
         pos[2] = longint'($signed(p.pos_z));
         vel[0] = longint'($signed(p.vel_x));
         vel[1] = longint'($signed(p.vel_y));
         vel[2] = longint'($signed(p.vel_z));
         gp = ft * gravity;
         grav = (gp + 10) / 20;
         grav30 = (gp * 3 + 1) >>> 1;
         dvel = ft * 4;
         for (int i = 0; i < 3; i++) pos[i] = clamp_q16(pos[i] + round_shift(vel[i] * ft, 16));
         case (p.kind)
            KIND_GRAV, KIND_SLOWGRAV: begin
               vel[2] = clamp_q16(vel[2] - grav);
            end
            KIND_FIRE: begin
               ramp_advance(ft, 5, 6, FIRE_COLORS, ramp, expiry, pal);
               vel[2] = clamp_q16(vel[2] + grav);
            end
            KIND_EXPLODE: begin
               ramp_advance(ft, 10, 8, BURST_COLORS, ramp, expiry, pal);
               for (int i = 0; i < 3; i++) vel[i] = scaled(vel[i], dvel, 1'b1);
               vel[2] = clamp_q16(vel[2] - grav30);
            end
            KIND_EXPLODE2: begin
               ramp_advance(ft, 15, 8, BURST2_COLORS, ramp, expiry, pal);
               for (int i = 0; i < 3; i++) vel[i] = scaled(vel[i], ft, 1'b0);
               vel[2] = clamp_q16(vel[2] - grav30);
            end
            KIND_BLOB: begin
               for (int i = 0; i < 3; i++) vel[i] = scaled(vel[i], dvel, 1'b1);
               vel[2] = clamp_q16(vel[2] - grav);
            end
            KIND_BLOB2: begin
               for (int i = 0; i < 2; i++) vel[i] = scaled(vel[i], dvel, 1'b0);
               vel[2] = clamp_q16(vel[2] - grav);
            end
            default: ;
         endcase
         r.alive = 1'b1;
         r.new_pos_x = pos[0][31:0];
         r.new_pos_y = pos[1][31:0];
         r.new_pos_z = pos[2][31:0];
         r.new_vel_x = vel[0][31:0];
         r.new_vel_y = vel[1][31:0];
         r.new_vel_z = vel[2][31:0];
         r.ramp_out = ramp[15:0];
         r.new_expiry = expiry[39:0];
         r.new_palette_index = pal;
         return r;
      endfunction

      function void note_input(req_type p);
         expected_particles.push_back(advance_particle(p));
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [39:0] got, logic [39:0] want);
         if (got !== want) begin
            report($sformatf("result beat %0d, %s: got %0h, expected %0h",
                             results_seen, name, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_particles.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing expected", results_seen));
            return;
         end
         want = expected_particles.pop_front();
         if (!want.alive) expired_seen++;
         compare_field("alive", got.alive, want.alive);
         compare_field("new_pos_x", got.new_pos_x, want.new_pos_x);
         compare_field("new_pos_y", got.new_pos_y, want.new_pos_y);
         compare_field("new_pos_z", got.new_pos_z, want.new_pos_z);
         compare_field("new_vel_x", got.new_vel_x, want.new_vel_x);
         compare_field("new_vel_y", got.new_vel_y, want.new_vel_y);
         compare_field("new_vel_z", got.new_vel_z, want.new_vel_z);
         compare_field("ramp_out", got.ramp_out, want.ramp_out);
         compare_field("new_expiry", got.new_expiry, want.new_expiry);
         compare_field("new_palette_index", got.new_palette_index, want.new_palette_index);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   frame_update_scoreboard sb;
   int cycles = 0;
   int idle_pct = 21;
   int settings_used = 0;

   particle_physics_update_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("particle_physics_update_top_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_data);
   end

   function automatic logic [39:0] random40();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[39:0];
   endfunction

   function automatic logic [31:0] random_q16();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      if (r < 17) return $urandom;
      if (r == 17) return POS_TOP - 32'($urandom_range(0, 1000));
      if (r == 18) return POS_BOT + 32'($urandom_range(0, 1000));
      return '0;
   endfunction

   function automatic req_type random_particle();
      req_type p;
      longint e;
      int r;
      int ramp_end;
      p.kind = 3'($urandom_range(0, 7));
      p.pos_x = random_q16();
      p.pos_y = random_q16();
      p.pos_z = random_q16();
      p.vel_x = random_q16();
      p.vel_y = random_q16();
      p.vel_z = random_q16();
      ramp_end = (p.kind == KIND_FIRE) ? 24576 : 32768;
      r = $urandom_range(0, 9);
      if (r < 7) p.ramp_in = 16'($urandom_range(0, ramp_end + 4096));
      else if (r < 9) p.ramp_in = 16'($urandom_range(0, 65535));
      else p.ramp_in = 16'(65535 - $urandom_range(0, 300));
      r = $urandom_range(0, 19);
      if (r < 15) e = sb.cur_time + longint'($urandom_range(0, 1 << 20));
      else if (r < 17) e = sb.cur_time - longint'($urandom_range(1, 1 << 20));
      else if (r == 17) e = sb.cur_time;
      else e = longint'($signed(random40()));
      if (e > TIME_MAX) e = TIME_MAX;
      if (e < TIME_MIN) e = TIME_MIN;
      p.expiry = e[39:0];
      p.palette_index = 8'($urandom_range(0, 255));
      return p;
   endfunction

   function automatic req_type particle(logic [2:0] k, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                        logic [31:0] vz, logic [15:0] ramp,
                                        logic [39:0] expiry, logic [7:0] pal);
      req_type p;
      p.kind = k;
      p.pos_x = px;
      p.pos_y = py;
      p.pos_z = pz;
      p.vel_x = vx;
      p.vel_y = vy;
      p.vel_z = vz;
      p.ramp_in = ramp;
      p.expiry = expiry;
      p.palette_index = pal;
      return p;
   endfunction

   task send_particle(input req_type p);
      start <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_input(p);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_data <= random_particle();
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      while (sb.expected_particles.size() != 0) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.apply_reg(idx, v);
   endtask

   task configure(input logic [16:0] ft, input logic [15:0] g, input logic [39:0] ct,
                  input logic pz);
      logic [39:0] junk;
      junk = random40();
      drain();
      write_reg(CSR_FRAME_TIME, {junk[39:17], ft});
      write_reg(CSR_GRAVITY, {junk[23:0], g});
      write_reg(CSR_CURRENT_TIME, ct);
      write_reg(CSR_PAUSED, {junk[38:0], pz});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task pick_settings(input int phase);
      logic [16:0] ft;
      logic [15:0] g;
      logic [39:0] ct;
      logic pz;
      int r;
      case (phase)
         0: begin
            ft = 17'd1092; g = 16'd800; ct = random40(); pz = 1'b0;
         end
         1: begin
            ft = 17'h1ffff; g = 16'hffff; ct = TIME_MIN[39:0]; pz = 1'b0;
         end
         2: begin
            ft = '0; g = '0; ct = TIME_MAX[39:0]; pz = 1'b0;
         end
         3: begin
            ft = 17'($urandom_range(1, 131071)); g = 16'($urandom); ct = random40();
            pz = 1'b1;
         end
         default: begin
            r = $urandom_range(0, 9);
            if (r == 0) ft = '0;
            else if (r == 1) ft = 17'h1ffff;
            else if (r < 6) ft = 17'($urandom_range(0, 131071));
            else ft = 17'($urandom_range(0, 8192));
            r = $urandom_range(0, 9);
            g = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom);
            ct = ($urandom_range(0, 1) == 0) ? random40() : 40'($urandom_range(0, 1 << 24));
            pz = ($urandom_range(0, 4) == 0);
         end
      endcase
      configure(ft, g, ct, pz);
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: time zero, no frame time, gravity at its reset strength.
      send_particle(particle(KIND_GRAV, 32'd100, 32'd200, 32'd300, 32'd65536, 32'd0,
                             32'd0, 16'd0, 40'hff_ffff_ffff, 8'd9));
      send_particle(particle(KIND_BLOB, 32'd100, 32'd200, 32'd300, 32'd65536, POS_TOP,
                             POS_BOT, 16'd0, 40'd0, 8'd9));
      drain();
      write_reg(CSR_FRAME_TIME, 40'd4369);
      csr_valid <= 1'b0;
      send_particle(particle(KIND_GRAV, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0,
                             16'd0, 40'd0, 8'd1));
      send_particle(particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             16'd0, 40'd0, 8'd1));

      configure(17'd4369, 16'd1000, T_NOW, 1'b0);
      send_particle(particle(KIND_STATIC, POS_TOP, POS_TOP, 32'd0, POS_TOP, POS_TOP, 32'd0,
                             16'hffff, T_NOW + 40'd5, 8'hff));
      send_particle(particle(KIND_STATIC, POS_BOT, POS_BOT, POS_BOT, POS_BOT, POS_BOT, POS_BOT,
                             16'd0, T_NOW + 40'd5, 8'h00));
      send_particle(particle(KIND_GRAV, 32'd5, 32'd6, 32'd7, 32'd1, 32'd2, 32'd3,
                             16'd100, T_NOW, 8'd7));
      send_particle(particle(KIND_SLOWGRAV, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             POS_BOT + 32'd5, 16'd0, T_NOW + 40'd1, 8'd7));
      send_particle(particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd100, 32'd100, 32'd100,
                             16'd0, T_NOW + 40'd9, 8'd2));
      send_particle(particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             16'd24575, T_NOW + 40'd9, 8'd2));
      send_particle(particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, POS_TOP,
                             16'd20480, T_NOW + 40'd9, 8'd2));
      send_particle(particle(KIND_EXPLODE, 32'd0, 32'd0, 32'd0, 32'd65536, 32'hffff_0000,
                             32'd0, 16'd0, T_NOW + 40'd9, 8'd3));
      send_particle(particle(KIND_EXPLODE, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1,
                             16'd32668, T_NOW + 40'd9, 8'd3));
      send_particle(particle(KIND_EXPLODE, POS_TOP, POS_BOT, 32'd0, POS_TOP, POS_BOT, POS_BOT,
                             16'd4096, T_NOW + 40'd9, 8'd3));
      send_particle(particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, POS_TOP, POS_BOT, 32'd0,
                             16'd24576, T_NOW + 40'd9, 8'd4));
      send_particle(particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             16'hffff, T_NOW + 40'd9, 8'd4));
      send_particle(particle(KIND_BLOB, 32'd0, 32'd0, 32'd0, POS_TOP, POS_TOP, POS_TOP,
                             16'd77, T_NOW + 40'd9, 8'd5));
      send_particle(particle(KIND_BLOB, 32'd0, 32'd0, 32'd0, POS_BOT, POS_BOT, POS_BOT,
                             16'd77, T_NOW + 40'd9, 8'd5));
      send_particle(particle(KIND_BLOB2, 32'd0, 32'd0, 32'd0, POS_BOT, POS_TOP, 32'd12345,
                             16'd77, T_NOW + 40'd9, 8'd6));
      send_particle(particle(KIND_BLOB2, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1,
                             16'd77, T_NOW - 40'd1, 8'd6));
      send_particle(particle(KIND_FIRE, POS_TOP, 32'd0, 32'd0, POS_TOP, 32'd0, 32'd0,
                             16'd100, TIME_MIN[39:0], 8'd6));
      send_particle(particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, 32'd7, 32'd7, 32'd7,
                             16'd200, TIME_MAX[39:0], 8'd8));
      send_particle(particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             16'd20480, T_NOW + 40'd9, 8'd8));
      send_particle(particle(KIND_STATIC, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             16'd0, T_NOW, 8'd0));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 4) idle_pct = 21;
         else if (phase < 8) idle_pct = 83;
         else idle_pct = 0;
         pick_settings(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_particle(random_particle());
      end

      drain();
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.expected_particles.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_particles.size()));
      end
      $display("Checked %0d particle beats, %0d of them expired and %0d ramps run out,",
               sb.results_seen, sb.expired_seen, sb.ramps_finished);
      $display("over %0d register settings with light, heavy and no input idling.",
               settings_used);
      if (sb.mismatches == 0) begin
         $display("particle_physics_update_top_tb passed");
      end else begin
         $display("particle_physics_update_top_tb failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/ppu_pkg.sv
rtl/ppu_cfg.sv
rtl/ppu_lane.sv
rtl/ppu_merge.sv
rtl/particle_physics_update_top.sv
rtl/ppu_checker.sv
verif/particle_physics_update_top_tb.sv
